FILE: hdl/page_table_walk_translate_defines.svh
// Assertion macros used by the walk sequencer of the page-table walk RTL.
// Depends on nothing; included by modules that carry assertions.
`ifndef PAGE_TABLE_WALK_TRANSLATE_DEFINES_SVH
`define PAGE_TABLE_WALK_TRANSLATE_DEFINES_SVH

// Same-cycle implication: the consequent must hold whenever the antecedent holds.
`define PTWT_ASSERT_SAME(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// Next-cycle implication: the consequent must hold in the cycle after the antecedent.
`define PTWT_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

FILE: hdl/ptwt_pkg.sv
// Shared types and constants for the four-level page-table walker.
// Depends on nothing; imported by every module of the block.
package ptwt_pkg;

   // Field widths of the transactions.
   localparam int VA_W              = 64;
   localparam int PA_W              = 52;
   localparam int ENTRY_W           = 64;
   localparam int SLOT_W            = 6;
   localparam int ROOT_W            = 6;
   localparam int ENTRIES_PER_TABLE = 512;
   localparam int IDX_W             = $clog2(ENTRIES_PER_TABLE);
   localparam int FRAME_NUM_W       = 40;
   localparam int PAGE_OFF_W        = 12;

   // Default store size in table frames.
   localparam int TABLE_FRAMES_DEF  = 64;

   // Entry bit positions.
   localparam int PRESENT_BIT       = 0;
   localparam int HUGE_BIT          = 7;

   // Request actions.
   localparam logic ACT_WRITE       = 1'b0;
   localparam logic ACT_TRANSLATE   = 1'b1;

   // Response status codes.
   typedef enum logic [2:0] {
      ST_OK         = 3'd0,
      ST_UNMAPPED   = 3'd1,
      ST_NONCANON   = 3'd2,
      ST_OUTSIDE    = 3'd3,
      ST_MISALIGNED = 3'd4
   } status_type;

   typedef struct packed {
      logic                 action;
      logic [SLOT_W-1:0]    table_slot;
      logic [IDX_W-1:0]     entry_index;
      logic [ENTRY_W-1:0]   entry_value;
      logic [VA_W-1:0]      vaddr;
   } req_type;

   typedef struct packed {
      logic [PA_W-1:0]      physical_address;
      status_type           status;
   } rsp_type;

endpackage

FILE: hdl/page_table_walk_translate.sv
// Four-level page-table walk. A table write goes to the store as it is accepted.
// A translation reads L table levels (L is 0 when rejected before the walk, at
// most 4), one dependent read per level from the registered-read store, then
// registers its result from the finish state; the next is taken in idle. One
// transaction is in flight; a result still waiting holds the next one at its end.
// Synchronous reset clears the control state and the root register, not the store.
module page_table_walk_translate #(
   parameter int TABLE_FRAMES = ptwt_pkg::TABLE_FRAMES_DEF
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          csr_valid,
   output logic                          csr_ready,
   input  logic [ptwt_pkg::ROOT_W-1:0]   csr_data,
   input  logic                          req_valid,
   output logic                          req_ready,
   input  ptwt_pkg::req_type             req_payload,
   output logic                          rsp_valid,
   input  logic                          rsp_ready,
   output ptwt_pkg::rsp_type             rsp_payload
);
   import ptwt_pkg::*;

   localparam int FRAME_W = (TABLE_FRAMES > 1) ? $clog2(TABLE_FRAMES) : 1;
   localparam int ADDR_W  = FRAME_W + IDX_W;
   localparam int DEPTH   = TABLE_FRAMES * ENTRIES_PER_TABLE;

   logic [ROOT_W-1:0]  root_frame_ff, root_frame_in;
   logic               mem_we;
   logic               mem_re;
   logic [ADDR_W-1:0]  mem_addr;
   logic [ENTRY_W-1:0] mem_wdata;
   logic [ENTRY_W-1:0] mem_rdata;

   // Root table register, written through the control port.
   assign csr_ready     = !reset;
   assign root_frame_in = (csr_valid && csr_ready) ? csr_data : root_frame_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         root_frame_ff <= '0;
      end else begin
         root_frame_ff <= root_frame_in;
      end
   end

   // Walk sequencer.
   ptwt_walk #(
      .TABLE_FRAMES (TABLE_FRAMES),
      .FRAME_W      (FRAME_W),
      .ADDR_W       (ADDR_W)
   ) u_walk (
      .clock       (clock),
      .reset       (reset),
      .root_frame  (root_frame_ff),
      .req_valid   (req_valid),
      .req_ready   (req_ready),
      .req_payload (req_payload),
      .rsp_valid   (rsp_valid),
      .rsp_ready   (rsp_ready),
      .rsp_payload (rsp_payload),
      .mem_we      (mem_we),
      .mem_re      (mem_re),
      .mem_addr    (mem_addr),
      .mem_wdata   (mem_wdata),
      .mem_rdata   (mem_rdata)
   );

   // Table store.
   ptwt_mem #(
      .DEPTH  (DEPTH),
      .ADDR_W (ADDR_W)
   ) u_mem (
      .clock   (clock),
      .wr_en   (mem_we),
      .rd_en   (mem_re),
      .addr    (mem_addr),
      .wr_data (mem_wdata),
      .rd_data (mem_rdata)
   );

endmodule

FILE: hdl/ptwt_mem.sv
// Single-port table store with a registered read.
// Depends on ptwt_pkg for the entry width.
module ptwt_mem #(
   parameter int DEPTH  = 32768,
   parameter int ADDR_W = 15
) (
   input  logic                          clock,
   input  logic                          wr_en,
   input  logic                          rd_en,
   input  logic [ADDR_W-1:0]             addr,
   input  logic [ptwt_pkg::ENTRY_W-1:0]  wr_data,
   output logic [ptwt_pkg::ENTRY_W-1:0]  rd_data
);
   import ptwt_pkg::*;

   logic [ENTRY_W-1:0] mem [DEPTH];
   logic [ENTRY_W-1:0] rd_data_ff;

   // Write and read share one address; the walker never does both at once.
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem[addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

FILE: hdl/ptwt_walk.sv
// Walk sequencer: accepts requests, drives the table store, holds the response.
// Depends on ptwt_pkg and the assertion macros in the defines header.
`include "page_table_walk_translate_defines.svh"

module ptwt_walk #(
   parameter int TABLE_FRAMES = ptwt_pkg::TABLE_FRAMES_DEF,
   parameter int FRAME_W      = 6,
   parameter int ADDR_W       = 15
) (
   input  logic                           clock,
   input  logic                           reset,
   input  logic [ptwt_pkg::ROOT_W-1:0]    root_frame,
   input  logic                           req_valid,
   output logic                           req_ready,
   input  ptwt_pkg::req_type              req_payload,
   output logic                           rsp_valid,
   input  logic                           rsp_ready,
   output ptwt_pkg::rsp_type              rsp_payload,
   output logic                           mem_we,
   output logic                           mem_re,
   output logic [ADDR_W-1:0]              mem_addr,
   output logic [ptwt_pkg::ENTRY_W-1:0]   mem_wdata,
   input  logic [ptwt_pkg::ENTRY_W-1:0]   mem_rdata
);
   import ptwt_pkg::*;

   typedef enum logic [2:0] {
      S_IDLE   = 3'b001,
      S_LOOKUP = 3'b010,
      S_FINISH = 3'b100
   } state_type;

   typedef enum logic [1:0] {
      LVL_1 = 2'd0,
      LVL_2 = 2'd1,
      LVL_3 = 2'd2,
      LVL_4 = 2'd3
   } level_type;

   localparam int                 VA_KEEP_W = 48;
   localparam logic [FRAME_NUM_W-1:0] FRAME_LIMIT = FRAME_NUM_W'(TABLE_FRAMES);

   state_type               state_ff, state_in;
   level_type               level_ff, level_in;
   logic [VA_KEEP_W-1:0]    va_ff, va_in;
   logic [PA_W-1:0]         res_pa_ff, res_pa_in;
   status_type              res_st_ff, res_st_in;
   logic                    rsp_valid_ff, rsp_valid_in;
   logic [PA_W-1:0]         rsp_pa_ff, rsp_pa_in;
   status_type              rsp_st_ff, rsp_st_in;

   logic                    out_free;
   logic                    va_noncanon;
   logic                    root_outside;
   logic                    slot_inside;
   logic [FRAME_NUM_W-1:0]  root_ext;
   logic [FRAME_NUM_W-1:0]  slot_ext;

   logic                    ent_present;
   logic                    ent_huge;
   logic [FRAME_NUM_W-1:0]  ent_frame;
   logic                    ent_outside;
   logic                    dec_fin;
   status_type              dec_st;
   logic [FRAME_NUM_W-1:0]  dec_frame;
   logic                    dec_next;
   logic [IDX_W-1:0]        dec_idx;
   level_type               dec_level;

   // Checks on the incoming transaction.
   assign root_ext     = {{(FRAME_NUM_W-ROOT_W){1'b0}}, root_frame};
   assign slot_ext     = {{(FRAME_NUM_W-SLOT_W){1'b0}}, req_payload.table_slot};
   assign root_outside = (root_ext >= FRAME_LIMIT);
   assign slot_inside  = (slot_ext < FRAME_LIMIT);
   assign va_noncanon  = (req_payload.vaddr[VA_W-1:VA_KEEP_W-1] != '0) &&
                         (req_payload.vaddr[VA_W-1:VA_KEEP_W-1] != '1);
   assign out_free     = !rsp_valid_ff || rsp_ready;

   // Fields of the entry returned by the store.
   assign ent_present = mem_rdata[PRESENT_BIT];
   assign ent_huge    = mem_rdata[HUGE_BIT];
   assign ent_frame   = mem_rdata[PAGE_OFF_W +: FRAME_NUM_W];
   assign ent_outside = (ent_frame >= FRAME_LIMIT);

   // Decode the entry for the current level: either finish or descend.
   always_comb begin
      dec_fin   = 1'b0;
      dec_st    = ST_OK;
      dec_frame = ent_frame;
      dec_next  = 1'b0;
      dec_idx   = va_ff[38:30];
      dec_level = LVL_3;
      unique case (level_ff)
         LVL_4: begin
            if (!ent_present || ent_huge) begin
               dec_fin = 1'b1;
               dec_st  = ST_UNMAPPED;
            end else if (ent_outside) begin
               dec_fin = 1'b1;
               dec_st  = ST_OUTSIDE;
            end else begin
               dec_next  = 1'b1;
               dec_idx   = va_ff[38:30];
               dec_level = LVL_3;
            end
         end
         LVL_3: begin
            if (!ent_present) begin
               dec_fin = 1'b1;
               dec_st  = ST_UNMAPPED;
            end else if (ent_huge) begin
               // A 1 GiB page needs a frame aligned to 2^18 frames.
               dec_fin   = 1'b1;
               dec_st    = (ent_frame[17:0] != '0) ? ST_MISALIGNED : ST_OK;
               dec_frame = {ent_frame[FRAME_NUM_W-1:18], va_ff[29:12]};
            end else if (ent_outside) begin
               dec_fin = 1'b1;
               dec_st  = ST_OUTSIDE;
            end else begin
               dec_next  = 1'b1;
               dec_idx   = va_ff[29:21];
               dec_level = LVL_2;
            end
         end
         LVL_2: begin
            if (!ent_present) begin
               dec_fin = 1'b1;
               dec_st  = ST_UNMAPPED;
            end else if (ent_huge) begin
               // A 2 MiB page needs a frame aligned to 2^9 frames.
               dec_fin   = 1'b1;
               dec_st    = (ent_frame[8:0] != '0) ? ST_MISALIGNED : ST_OK;
               dec_frame = {ent_frame[FRAME_NUM_W-1:9], va_ff[20:12]};
            end else if (ent_outside) begin
               dec_fin = 1'b1;
               dec_st  = ST_OUTSIDE;
            end else begin
               dec_next  = 1'b1;
               dec_idx   = va_ff[20:12];
               dec_level = LVL_1;
            end
         end
         LVL_1: begin
            // The huge bit means nothing here; a present entry maps 4 KiB.
            dec_fin = 1'b1;
            dec_st  = ent_present ? ST_OK : ST_UNMAPPED;
         end
         default: begin
            dec_fin = 1'b1;
            dec_st  = ST_UNMAPPED;
         end
      endcase
   end

   // Sequencer. Writes and reads of the store never overlap, since only one
   // transaction is in flight and writes are taken only while idle.
   always_comb begin
      state_in     = state_ff;
      level_in     = level_ff;
      va_in        = va_ff;
      res_pa_in    = res_pa_ff;
      res_st_in    = res_st_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      rsp_pa_in    = rsp_pa_ff;
      rsp_st_in    = rsp_st_ff;
      mem_we       = 1'b0;
      mem_re       = 1'b0;
      mem_addr     = '0;
      mem_wdata    = req_payload.entry_value;
      req_ready    = 1'b0;
      unique case (state_ff)
         S_IDLE: begin
            req_ready = !reset;
            if (req_valid && !reset) begin
               if (req_payload.action == ACT_WRITE) begin
                  mem_we   = slot_inside;
                  mem_addr = {slot_ext[FRAME_W-1:0], req_payload.entry_index};
               end else begin
                  va_in     = req_payload.vaddr[VA_KEEP_W-1:0];
                  res_pa_in = '0;
                  if (va_noncanon) begin
                     res_st_in = ST_NONCANON;
                     state_in  = S_FINISH;
                  end else if (root_outside) begin
                     res_st_in = ST_OUTSIDE;
                     state_in  = S_FINISH;
                  end else begin
                     mem_re   = 1'b1;
                     mem_addr = {root_ext[FRAME_W-1:0],
                                 req_payload.vaddr[47:39]};
                     level_in = LVL_4;
                     state_in = S_LOOKUP;
                  end
               end
            end
         end
         S_LOOKUP: begin
            if (dec_fin) begin
               res_st_in = dec_st;
               res_pa_in = (dec_st == ST_OK) ? {dec_frame, va_ff[PAGE_OFF_W-1:0]} : '0;
               state_in  = S_FINISH;
            end else if (dec_next) begin
               mem_re   = 1'b1;
               mem_addr = {ent_frame[FRAME_W-1:0], dec_idx};
               level_in = dec_level;
            end
         end
         S_FINISH: begin
            if (out_free) begin
               rsp_valid_in = 1'b1;
               rsp_pa_in    = res_pa_ff;
               rsp_st_in    = res_st_ff;
               state_in     = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   // Control registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         level_ff     <= LVL_4;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         level_ff     <= level_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // Payload registers.
   always_ff @(posedge clock) begin
      va_ff     <= va_in;
      res_pa_ff <= res_pa_in;
      res_st_ff <= res_st_in;
      rsp_pa_ff <= rsp_pa_in;
      rsp_st_ff <= rsp_st_in;
   end

   assign rsp_valid                    = rsp_valid_ff;
   assign rsp_payload.physical_address = rsp_pa_ff;
   assign rsp_payload.status           = rsp_st_ff;

   // Checks on the sequencer.
   `PTWT_ASSERT_SAME(a_no_rw_overlap, clock, reset, mem_we, !mem_re, "store read and write collide")
   `PTWT_ASSERT_NEXT(a_read_then_lookup, clock, reset, mem_re, state_ff == S_LOOKUP, "read without lookup")
   `PTWT_ASSERT_SAME(a_error_zero_pa, clock, reset, rsp_valid_ff && (rsp_st_ff != ST_OK), rsp_pa_ff == '0, "error response with nonzero address")
   `PTWT_ASSERT_NEXT(a_finish_delivers, clock, reset, (state_ff == S_FINISH) && out_free, rsp_valid_ff, "finished walk not presented")

endmodule

FILE: verif/tb_top.sv
// Self-checking testbench for the four-level page-table walker page_table_walk_translate.
// Depends on ptwt_pkg and the block's RTL only; a scoreboard class predicts each translation.
module tb_top;
   timeunit 1ns;
   timeprecision 1ps;

   import ptwt_pkg::*;

   localparam int STALL_LIMIT  = 2000;
   localparam int SETTLE_TICKS = 20;
   localparam int PHASE_ITEMS  = 112;

   // Predicts the block from its own copy of the table store and the root register.
   class translation_scoreboard;
      logic [ENTRY_W-1:0] table_mem [int];
      logic [ROOT_W-1:0]  root_frame;
      rsp_type            expected_results [$];
      int                 errors;

      function new();
         root_frame = '0;
         errors     = 0;
      endfunction

      function void set_root(input logic [ROOT_W-1:0] value);
         root_frame = value;
      endfunction

      function int pending();
         return expected_results.size();
      endfunction

      // Walks the tables for one address. Returns the store position of the first
      // entry that the walk would read before it was ever written, or -1.
      function int walk(input logic [VA_W-1:0] va, output status_type st,
                        output logic [PA_W-1:0] pa, output int miss_level);
         logic [IDX_W-1:0]       idx;
         logic [ENTRY_W-1:0]     ent;
         logic [FRAME_NUM_W-1:0] fr;
         int                     frame;
         int                     slot;
         st         = ST_OK;
         pa         = '0;
         miss_level = 0;
         if (va[63:47] != '0 && va[63:47] != '1) begin
            st = ST_NONCANON;
            return -1;
         end
         frame = int'(root_frame);
         if (frame >= TABLE_FRAMES_DEF) begin
            st = ST_OUTSIDE;
            return -1;
         end
         for (int level = 4; level >= 1; level--) begin
            idx  = IDX_W'(va >> (PAGE_OFF_W + IDX_W * (level - 1)));
            slot = frame * ENTRIES_PER_TABLE + int'(idx);
            if (!table_mem.exists(slot)) begin
               miss_level = level;
               return slot;
            end
            ent = table_mem[slot];
            fr  = ent[51:12];
            // A huge bit at the top level does not lead anywhere.
            if (!ent[PRESENT_BIT] || (level == 4 && ent[HUGE_BIT])) begin
               st = ST_UNMAPPED;
               return -1;
            end
            // The last level maps 4 KiB whatever its huge bit says.
            if (level == 1) begin
               pa = {fr, va[11:0]};
               return -1;
            end
            if (ent[HUGE_BIT] && level == 3) begin
               if (fr[17:0] != '0) st = ST_MISALIGNED;
               else pa = {fr[39:18], va[29:0]};
               return -1;
            end
            if (ent[HUGE_BIT] && level == 2) begin
               if (fr[8:0] != '0) st = ST_MISALIGNED;
               else pa = {fr[39:9], va[20:0]};
               return -1;
            end
            if (fr >= 40'(TABLE_FRAMES_DEF)) begin
               st = ST_OUTSIDE;
               return -1;
            end
            frame = int'(fr);
         end
         return -1;
      endfunction

      // Updates the store on a write, or queues the predicted result of a translation.
      function void note_request(input req_type r);
         rsp_type          want;
         status_type       st;
         logic [PA_W-1:0]  pa;
         int               miss_level;
         if (r.action == ACT_WRITE) begin
            if (int'(r.table_slot) < TABLE_FRAMES_DEF)
               table_mem[int'(r.table_slot) * ENTRIES_PER_TABLE + int'(r.entry_index)] =
                  r.entry_value;
         end else begin
            if (walk(r.vaddr, st, pa, miss_level) >= 0) begin
               $display("%0t: translation of %h reads an unwritten table entry",
                        $time, r.vaddr);
               errors++;
            end
            want.physical_address = pa;
            want.status           = st;
            expected_results.push_back(want);
         end
      endfunction

      // Compares one result transaction with the oldest prediction.
      function void check_response(input rsp_type got);
         rsp_type want;
         if (expected_results.size() == 0) begin
            $display("%0t: unexpected result, actual address %h status %0d",
                     $time, got.physical_address, got.status);
            errors++;
            return;
         end
         want = expected_results.pop_front();
         if (got.physical_address !== want.physical_address) begin
            $display("%0t: physical_address mismatch, expected %h, actual %h",
                     $time, want.physical_address, got.physical_address);
            errors++;
         end
         if (got.status !== want.status) begin
            $display("%0t: status mismatch, expected %0d, actual %0d",
                     $time, want.status, got.status);
            errors++;
         end
      endfunction
   endclass

   logic                clock = 1'b0;
   logic                reset;
   logic                csr_valid;
   logic                csr_ready;
   logic [ROOT_W-1:0]   csr_data;
   logic                req_valid;
   logic                req_ready;
   req_type             req_payload;
   logic                rsp_valid;
   logic                rsp_ready;
   rsp_type             rsp_payload;

   translation_scoreboard table_sb = new();
   logic [VA_W-1:0]     recent_va [$];
   bit                  req_steady = 1'b0;
   bit                  rsp_steady = 1'b0;
   int                  idle_cycles = 0;
   int                  sent_items = 0;

   page_table_walk_translate i_dut (
      .clock       (clock),
      .reset       (reset),
      .csr_valid   (csr_valid),
      .csr_ready   (csr_ready),
      .csr_data    (csr_data),
      .req_valid   (req_valid),
      .req_ready   (req_ready),
      .req_payload (req_payload),
      .rsp_valid   (rsp_valid),
      .rsp_ready   (rsp_ready),
      .rsp_payload (rsp_payload)
   );

   always begin
      #5ns clock = 1'b1;
      #5ns clock = 1'b0;
   end

   // Monitor every handshake and keep a watchdog on cycles with no transaction.
   always @(posedge clock) begin
      if (!reset) begin
         if (csr_valid && csr_ready) table_sb.set_root(csr_data);
         if (req_valid && req_ready) table_sb.note_request(req_payload);
         if (rsp_valid && rsp_ready) table_sb.check_response(rsp_payload);
      end
      if (reset || (csr_valid && csr_ready) || (req_valid && req_ready) ||
          (rsp_valid && rsp_ready)) begin
         idle_cycles <= 0;
      end else if (idle_cycles >= STALL_LIMIT) begin
         $display("FAILURE");
         $finish;
      end else begin
         idle_cycles <= idle_cycles + 1;
      end
   end

   // Result side: stall a random number of cycles before taking each result.
   initial begin
      int stall;
      rsp_ready = 1'b0;
      @(negedge clock);
      while (reset) @(negedge clock);
      forever begin
         if ($urandom_range(0, 39) == 0) rsp_steady = !rsp_steady;
         stall = rsp_steady ? 0 : int'($urandom_range(0, 19));
         if (stall > 0) begin
            rsp_ready <= 1'b0;
            repeat (stall) @(negedge clock);
         end
         rsp_ready <= 1'b1;
         @(posedge clock);
         while (!rsp_valid) @(posedge clock);
         @(negedge clock);
      end
   end

   // Index picker that mostly reuses a few table positions so walks go deep.
   function automatic logic [IDX_W-1:0] pick_index();
      int pick;
      pick = $urandom_range(0, 99);
      if (pick < 60) return IDX_W'($urandom_range(0, 3));
      if (pick < 70) return IDX_W'(511 - $urandom_range(0, 3));
      return IDX_W'($urandom_range(0, 511));
   endfunction

   function automatic logic [ENTRY_W-1:0] make_entry(input int level);
      int                     pick;
      logic [FRAME_NUM_W-1:0] fr;
      logic [ENTRY_W-1:0]     e;
      pick = $urandom_range(0, 99);
      fr   = {8'($urandom), $urandom};
      e    = {$urandom, $urandom};
      e[PRESENT_BIT] = 1'b1;
      e[HUGE_BIT]    = 1'b0;
      if (level == 1) begin
         if (pick < 15) e[PRESENT_BIT] = 1'b0;
      end else if (pick < 58) begin
         fr = 40'($urandom_range(0, TABLE_FRAMES_DEF - 1));
      end else if (pick < 66) begin
         e[PRESENT_BIT] = 1'b0;
      end else if (pick < 74) begin
         fr = fr | (40'd1 << $urandom_range(6, 39));
      end else if (pick < 88) begin
         // Huge page with a properly aligned frame.
         e[HUGE_BIT] = 1'b1;
         if (level == 3) fr[17:0] = '0;
         else fr[8:0] = '0;
      end else if (pick < 95) begin
         // Huge page whose frame is not aligned to the page size.
         e[HUGE_BIT] = 1'b1;
         fr = fr | (40'd1 << $urandom_range(0, (level == 3) ? 17 : 8));
      end else begin
         return {$urandom, $urandom};
      end
      e[51:12] = fr;
      return e;
   endfunction

   // Canonical address built from a few popular indices, or a recently used one.
   function automatic logic [VA_W-1:0] make_address();
      logic [VA_W-1:0]  va;
      logic [IDX_W-1:0] top_idx;
      bit               upper;
      upper = 1'($urandom);
      if (recent_va.size() > 0 && $urandom_range(0, 3) == 0) begin
         va = recent_va[$urandom_range(0, recent_va.size() - 1)];
         va[11:0] = 12'($urandom);
         return va;
      end
      top_idx = pick_index();
      top_idx[8] = upper;
      va = {{16{upper}}, top_idx, pick_index(), pick_index(), pick_index(), 12'($urandom)};
      recent_va.push_back(va);
      if (recent_va.size() > 32) void'(recent_va.pop_front());
      return va;
   endfunction

   function automatic req_type random_request();
      req_type r;
      r.action      = 1'($urandom);
      r.table_slot  = SLOT_W'($urandom);
      r.entry_index = IDX_W'($urandom);
      r.entry_value = {$urandom, $urandom};
      r.vaddr       = {$urandom, $urandom};
      return r;
   endfunction

   // Presents one transaction after a random gap and holds it until accepted.
   task automatic push_request(input req_type item);
      int gap;
      if ($urandom_range(0, 39) == 0) req_steady = !req_steady;
      gap = req_steady ? 0 : int'($urandom_range(0, 19));
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(negedge clock);
      end
      req_valid   <= 1'b1;
      req_payload <= item;
      @(posedge clock);
      while (!req_ready) @(posedge clock);
      sent_items++;
      @(negedge clock);
   endtask

   task automatic push_write(input int frame, input int idx, input logic [ENTRY_W-1:0] value);
      req_type item;
      item             = random_request();
      item.action      = ACT_WRITE;
      item.table_slot  = SLOT_W'(frame);
      item.entry_index = IDX_W'(idx);
      item.entry_value = value;
      push_request(item);
   endtask

   // Writes any table entry on the walk path that was never written, then translates.
   task automatic run_translate(input logic [VA_W-1:0] va);
      req_type          item;
      status_type       st;
      logic [PA_W-1:0]  pa;
      int               miss_level;
      int               miss;
      miss = table_sb.walk(va, st, pa, miss_level);
      while (miss >= 0) begin
         push_write(miss / ENTRIES_PER_TABLE, miss % ENTRIES_PER_TABLE, make_entry(miss_level));
         miss = table_sb.walk(va, st, pa, miss_level);
      end
      item        = random_request();
      item.action = ACT_TRANSLATE;
      item.vaddr  = va;
      push_request(item);
   endtask

   // The root register is only written once the walker has drained.
   task automatic load_root(input logic [ROOT_W-1:0] value);
      req_valid <= 1'b0;
      while (table_sb.pending() != 0) @(negedge clock);
      repeat (10) @(negedge clock);
      csr_valid <= 1'b1;
      csr_data  <= value;
      @(posedge clock);
      while (!csr_ready) @(posedge clock);
      @(negedge clock);
      csr_valid <= 1'b0;
   endtask

   task automatic random_item();
      int pick;
      pick = $urandom_range(0, 99);
      if (pick < 70) begin
         run_translate(make_address());
      end else if (pick < 80) begin
         run_translate({$urandom, $urandom});
      end else if (pick < 90) begin
         push_write(int'($urandom_range(0, 63)), int'(pick_index()), {$urandom, $urandom});
      end else begin
         push_write(int'($urandom_range(0, 63)), int'(pick_index()),
                    make_entry(int'($urandom_range(1, 4))));
      end
   endtask

   initial begin
      logic [ROOT_W-1:0] roots [6];
      int                phase_end;
      roots[0] = ROOT_W'(63);
      roots[1] = ROOT_W'($urandom);
      roots[2] = '0;
      roots[3] = ROOT_W'($urandom);
      roots[4] = ROOT_W'(1);
      roots[5] = ROOT_W'($urandom);

      reset       = 1'b1;
      csr_valid   = 1'b0;
      csr_data    = '0;
      req_valid   = 1'b0;
      req_payload = '0;
      repeat (9) @(negedge clock);
      reset <= 1'b0;
      load_root('0);

      // Directed tables: frame 0 is the root, frames 1, 2 and 63 hang below it.
      push_write(0, 0, 64'hFFF0_0000_0000_1F7F);
      push_write(1, 0, 64'h0000_0000_4000_0081);
      push_write(1, 1, 64'h0000_0000_4000_1081);
      push_write(1, 2, 64'h0000_0000_0000_2003);
      push_write(1, 3, 64'h0000_0001_0000_0001);
      push_write(2, 0, 64'h0000_0000_0020_0081);
      push_write(2, 1, 64'h0000_0000_0020_1081);
      push_write(2, 2, 64'h0000_0000_0003_F001);
      push_write(2, 3, 64'h0000_0000_0004_0001);
      push_write(63, 0, 64'hFFFF_FFFF_FFFF_FFFF);
      push_write(63, 1, 64'h0000_0000_0000_0000);
      push_write(0, 1, 64'h0000_0000_0000_0081);
      push_write(0, 2, 64'hFFFF_FFFF_FFFF_F001);
      push_write(0, 256, 64'hFFFF_FFFF_FFFF_FFFE);

      // Non-canonical addresses on both sides of the hole.
      run_translate(64'h0000_8000_0000_0000);
      run_translate(64'hFFFF_7FFF_FFFF_FFFF);
      // 1 GiB page, aligned and misaligned.
      run_translate(64'h0000_0000_3FFF_FFFF);
      run_translate(64'h0000_0000_4000_0000);
      // 2 MiB page, aligned and misaligned.
      run_translate(64'h0000_0000_8000_1234);
      run_translate(64'h0000_0000_8020_0000);
      // 4 KiB page with the huge bit set at the last level, then a missing page.
      run_translate(64'h0000_0000_8040_0ABC);
      run_translate(64'h0000_0000_8040_1000);
      // Table pointers beyond the store at levels 2, 3 and 4.
      run_translate(64'h0000_0000_8060_0000);
      run_translate(64'h0000_0000_C000_0000);
      run_translate(64'h0000_0100_0000_0000);
      // Huge bit at the top level, and an absent entry in the upper half.
      run_translate(64'h0000_0080_0000_0000);
      run_translate(64'hFFFF_8000_0000_0000);

      // Random phases, each under its own root table and with a fixed share
      // of input transactions, table fills included.
      foreach (roots[p]) begin
         load_root(roots[p]);
         phase_end = sent_items + PHASE_ITEMS;
         while (sent_items < phase_end) random_item();
      end

      req_valid <= 1'b0;
      while (table_sb.pending() != 0) @(negedge clock);
      repeat (SETTLE_TICKS) @(negedge clock);
      if (table_sb.errors == 0 && table_sb.pending() == 0) begin
         $display("SUCCESS");
      end else begin
         $display("FAILURE");
      end
      $finish;
   end

endmodule

FILE: sim.f
+incdir+hdl
hdl/ptwt_pkg.sv
hdl/ptwt_mem.sv
hdl/ptwt_walk.sv
hdl/page_table_walk_translate.sv
verif/tb_top.sv
